[src/dlvl_pkg.sv]
// ----------------------------------------------------------------------------
// Doubly linked value list package
// Sizes, link and value types, operation and status codes shared by the
// list controller and the testbench.
// ----------------------------------------------------------------------------
package dlvl_pkg;

   // Node pool size and stored value width.
   localparam int CAPACITY   = 32;
   localparam int VALUE_BITS = 32;

   // A node index addresses the pool; a link can also hold the null marker.
   localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LINK_BITS = $clog2(CAPACITY + 1);

   // Fixed field widths of the stream channels.
   localparam int ITEM_BITS     = 32;
   localparam int COUNT_BITS    = 6;
   localparam int STATUS_BITS   = 3;
   localparam int MODE_BITS     = 2;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 40;

   typedef logic [LINK_BITS-1:0]  link_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   localparam link_type NULL_LINK = LINK_BITS'(CAPACITY);

   typedef enum logic [MODE_BITS-1:0] {
      MODE_APPEND    = 2'd0,
      MODE_DELETE    = 2'd1,
      MODE_DUMP_FWD  = 2'd2,
      MODE_DUMP_BACK = 2'd3
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_APPENDED  = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_DELETED   = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_ELEMENT   = 3'd4,
      STATUS_EMPTY     = 3'd5
   } status_type;

endpackage

[src/dlvl_ram.sv]
// ----------------------------------------------------------------------------
// Generic node RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
module dlvl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/doubly_linked_value_list.sv]
// ----------------------------------------------------------------------------
// Doubly linked value list
// Ordered list of signed values in a fixed pool of nodes with forward and
// backward links: append at the tail, delete the first match, dump forward
// or backward.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                      Contents
//  req_      in         tvalid tready tdata tuser    tdata: item_value
//                                                    tuser: mode
//  rsp_      out        tvalid tready tdata tuser    tdata: out_value, entry_count
//                       tlast                        tuser: status, tlast: last
//
// An append runs a free node scan that tests one in-use bit per cycle. A
// delete walks from the head with one node memory read per cycle. A dump
// gives one result transfer per cycle while the result side keeps up.
// Reset clears the in-use bits, head, tail and count at once; the node
// memories are never cleared, since every node is written before it is read.
// A stalled result side holds a dump walk in place; a new request is taken
// once the previous operation is finished, even while its last result
// still waits in the output register.
// ----------------------------------------------------------------------------
module doubly_linked_value_list (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dlvl_pkg::REQ_DATA_BITS-1:0]  req_tdata,   // [31:0] item_value
   input  logic [dlvl_pkg::MODE_BITS-1:0]      req_tuser,   // [1:0] mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dlvl_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,   // [31:0] out_value,
                                                            // [37:32] entry_count,
                                                            // [39:38] zero
   output logic [dlvl_pkg::STATUS_BITS-1:0]    rsp_tuser,   // [2:0] status
   output logic                                rsp_tlast
);

   import dlvl_pkg::*;

   // Controller states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ALLOC = 6'b000010,
      ST_LINK  = 6'b000100,
      ST_DEL   = 6'b001000,
      ST_DUMP  = 6'b010000,
      ST_REPLY = 6'b100000
   } state_type;

   // A link is usable when it points into the pool at a node that is in use.
   function automatic logic link_ok(input link_type x, input logic [CAPACITY-1:0] used);
      logic ok;
      ok = (x < NULL_LINK) && used[x[IDX_BITS-1:0]];
      return ok;
   endfunction

   // ------------------------------------------------------------------------
   // Control and list registers.
   // ------------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [CAPACITY-1:0]   in_use_ff, in_use_in;
   link_type              head_ff, head_in;
   link_type              tail_ff, tail_in;
   link_type              count_ff, count_in;
   link_type              cur_ff, cur_in;       // node being visited by a walk
   idx_type               scan_ff, scan_in;     // free node scan position
   idx_type               alloc_ff, alloc_in;   // node taken by an append
   logic                  dir_fwd_ff, dir_fwd_in;
   value_type             key_ff, key_in;
   logic [ITEM_BITS-1:0]  echo_ff, echo_in;
   status_type            pend_ff, pend_in;     // status of a single-result reply

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ITEM_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Node memory ports. All three memories share one read address, so a
   // walk sees a node's value and both links in the same cycle.
   idx_type               rd_addr;
   value_type             val_rd;
   link_type              next_rd, prev_rd;
   logic                  val_we, next_we, prev_we;
   idx_type               val_wa, next_wa, prev_wa;
   value_type             val_wd;
   link_type              next_wd, prev_wd;

   logic                  can_emit;
   logic                  req_fire;
   link_type              dump_nx;
   logic                  dump_more;

   dlvl_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_wd),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   dlvl_ram #(.WIDTH(LINK_BITS), .DEPTH(CAPACITY)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   dlvl_ram #(.WIDTH(LINK_BITS), .DEPTH(CAPACITY)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   // The output register can take a result when it is empty or being drained.
   assign can_emit   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // During a dump the link followed depends on the direction.
   assign dump_nx   = dir_fwd_ff ? next_rd : prev_rd;
   assign dump_more = link_ok(dump_nx, in_use_ff);

   // ------------------------------------------------------------------------
   // Next-state logic. Writes to the node memories never share a cycle with
   // a read of the same node that matters: every write happens in a state
   // that is followed by another state before the next walk reads.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      in_use_in     = in_use_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      scan_in       = scan_ff;
      alloc_in      = alloc_ff;
      dir_fwd_in    = dir_fwd_ff;
      key_in        = key_ff;
      echo_in       = echo_ff;
      pend_in       = pend_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      rd_addr = cur_ff[IDX_BITS-1:0];
      val_we  = 1'b0;
      val_wa  = scan_ff;
      val_wd  = key_ff;
      next_we = 1'b0;
      next_wa = scan_ff;
      next_wd = NULL_LINK;
      prev_we = 1'b0;
      prev_wa = scan_ff;
      prev_wd = tail_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // Values are kept sign-extended to the stored width.
               key_in  = VALUE_BITS'(signed'(req_tdata[ITEM_BITS-1:0]));
               echo_in = req_tdata[ITEM_BITS-1:0];
               unique case (mode_type'(req_tuser))
                  MODE_APPEND: begin
                     if (count_ff == NULL_LINK) begin
                        pend_in  = STATUS_FULL;
                        state_in = ST_REPLY;
                     end else begin
                        scan_in  = '0;
                        state_in = ST_ALLOC;
                     end
                  end
                  MODE_DELETE: begin
                     if (link_ok(head_ff, in_use_ff)) begin
                        rd_addr  = head_ff[IDX_BITS-1:0];
                        cur_in   = head_ff;
                        state_in = ST_DEL;
                     end else begin
                        pend_in  = STATUS_NOT_FOUND;
                        state_in = ST_REPLY;
                     end
                  end
                  MODE_DUMP_FWD, MODE_DUMP_BACK: begin
                     dir_fwd_in = (mode_type'(req_tuser) == MODE_DUMP_FWD);
                     cur_in     = (mode_type'(req_tuser) == MODE_DUMP_FWD) ? head_ff : tail_ff;
                     if (link_ok(cur_in, in_use_ff)) begin
                        rd_addr  = cur_in[IDX_BITS-1:0];
                        state_in = ST_DUMP;
                     end else begin
                        // An empty dump reports a zero value.
                        echo_in  = '0;
                        pend_in  = STATUS_EMPTY;
                        state_in = ST_REPLY;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_ALLOC: begin
            if (!in_use_ff[scan_ff]) begin
               // Lowest free node found: fill it and hang it after the tail.
               val_we            = 1'b1;
               next_we           = 1'b1;
               prev_we           = 1'b1;
               in_use_in[scan_ff] = 1'b1;
               count_in          = count_ff + 1'b1;
               alloc_in          = scan_ff;
               pend_in           = STATUS_APPENDED;
               if (link_ok(tail_ff, in_use_ff)) begin
                  state_in = ST_LINK;
               end else begin
                  head_in  = LINK_BITS'(scan_ff);
                  tail_in  = LINK_BITS'(scan_ff);
                  state_in = ST_REPLY;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_LINK: begin
            // Forward link from the old tail to the new node.
            next_we  = 1'b1;
            next_wa  = tail_ff[IDX_BITS-1:0];
            next_wd  = LINK_BITS'(alloc_ff);
            tail_in  = LINK_BITS'(alloc_ff);
            state_in = ST_REPLY;
         end

         ST_DEL: begin
            if (val_rd == key_ff) begin
               // Unlink the node between its neighbors.
               if (link_ok(prev_rd, in_use_ff)) begin
                  next_we = 1'b1;
                  next_wa = prev_rd[IDX_BITS-1:0];
                  next_wd = next_rd;
               end else begin
                  head_in = next_rd;
               end
               if (link_ok(next_rd, in_use_ff)) begin
                  prev_we = 1'b1;
                  prev_wa = next_rd[IDX_BITS-1:0];
                  prev_wd = prev_rd;
               end else begin
                  tail_in = prev_rd;
               end
               in_use_in[cur_ff[IDX_BITS-1:0]] = 1'b0;
               count_in = count_ff - 1'b1;
               pend_in  = STATUS_DELETED;
               state_in = ST_REPLY;
            end else if (link_ok(next_rd, in_use_ff)) begin
               rd_addr = next_rd[IDX_BITS-1:0];
               cur_in  = next_rd;
            end else begin
               pend_in  = STATUS_NOT_FOUND;
               state_in = ST_REPLY;
            end
         end

         ST_DUMP: begin
            // While stalled, the read repeats at the current node so that
            // its data stays on the memory outputs.
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_ELEMENT;
               rsp_value_in  = ITEM_BITS'(val_rd);
               rsp_count_in  = COUNT_BITS'(count_ff);
               rsp_last_in   = !dump_more;
               if (dump_more) begin
                  rd_addr = dump_nx[IDX_BITS-1:0];
                  cur_in  = dump_nx;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_REPLY: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_ff;
               rsp_value_in  = echo_ff;
               rsp_count_in  = COUNT_BITS'(count_ff);
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= '0;
         head_ff      <= NULL_LINK;
         tail_ff      <= NULL_LINK;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      scan_ff       <= scan_in;
      alloc_ff      <= alloc_in;
      dir_fwd_ff    <= dir_fwd_in;
      key_ff        <= key_in;
      echo_ff       <= echo_in;
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - ITEM_BITS - COUNT_BITS)'(0), rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NULL_LINK)
      else $error("entry count exceeds the pool size");

   a_count_matches_use: assert property (@(posedge clock) disable iff (reset)
      $countones(in_use_ff) == int'(count_ff))
      else $error("entry count disagrees with the in-use bits");

   a_head_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (head_ff == NULL_LINK))
      else $error("head pointer disagrees with the entry count");

   a_tail_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (tail_ff == NULL_LINK))
      else $error("tail pointer disagrees with the entry count");

   a_walk_on_live_node: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEL || state_ff == ST_DUMP) |-> link_ok(cur_ff, in_use_ff))
      else $error("list walk reached a node that is not in use");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Doubly linked value list testbench
// Drives list operations on the request stream and checks every result
// transfer against a behavioral copy of the list kept in the bench. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dlvl_pkg::*;

   // One expected result transfer, split into its fields.
   typedef struct {
      status_type             status;
      logic [ITEM_BITS-1:0]   value;
      logic [COUNT_BITS-1:0]  count;
      logic                   last;
   } list_rsp_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;
   logic [MODE_BITS-1:0]      req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [STATUS_BITS-1:0]    rsp_tuser;
   logic                      rsp_tlast;

   // Bench copy of the node pool and its links. The null marker is CAPACITY.
   value_type  list_value [CAPACITY];
   link_type   fwd_link   [CAPACITY];
   link_type   back_link  [CAPACITY];
   logic       node_busy  [CAPACITY];
   link_type   head_link;
   link_type   tail_link;
   int         list_len;

   // Result transfers that the accepted requests still owe, oldest first.
   list_rsp_type  pending_rsp [$];
   int            mismatch_count = 0;

   // Random pacing state for both stream sides.
   int         sender_quiet = 0;
   int         stall_left   = 0;
   int         ready_quiet  = 0;

   doubly_linked_value_list DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // List behavior
   // ---------------------------------------------------------------------

   // A link points at a live node only when it is inside the pool and that
   // node is in use; the null marker never is.
   function automatic logic link_live(input link_type l);
      if (l >= link_type'(CAPACITY)) begin
         return 1'b0;
      end
      return node_busy[l[IDX_BITS-1:0]];
   endfunction

   task automatic push_expected(input status_type st, input logic [ITEM_BITS-1:0] v,
                                input logic fin);
      list_rsp_type r;
      r.status = st;
      r.value  = v;
      r.count  = COUNT_BITS'(list_len);
      r.last   = fin;
      pending_rsp = {pending_rsp, r};
   endtask

   task automatic reset_list();
      for (int i = 0; i < CAPACITY; i++) begin
         node_busy[i]  = 1'b0;
         list_value[i] = '0;
         fwd_link[i]   = NULL_LINK;
         back_link[i]  = NULL_LINK;
      end
      head_link = NULL_LINK;
      tail_link = NULL_LINK;
      list_len  = 0;
   endtask

   // Applies one accepted request to the bench list and queues the results
   // that it owes. The count field always reflects the list after the update.
   task automatic apply_list_op(input mode_type op, input logic [ITEM_BITS-1:0] item);
      int        slot;
      int        walked;
      link_type  cur;
      link_type  nxt;
      link_type  p;
      link_type  q;
      logic      found;
      case (op)
         MODE_APPEND: begin
            // The lowest-numbered free node is taken.
            slot = -1;
            for (int i = CAPACITY - 1; i >= 0; i--) begin
               if (!node_busy[i]) slot = i;
            end
            if (slot < 0) begin
               push_expected(STATUS_FULL, item, 1'b1);
            end else begin
               node_busy[slot]  = 1'b1;
               list_value[slot] = item;
               fwd_link[slot]   = NULL_LINK;
               back_link[slot]  = tail_link;
               if (link_live(tail_link)) begin
                  fwd_link[tail_link[IDX_BITS-1:0]] = link_type'(slot);
               end else begin
                  head_link = link_type'(slot);
               end
               tail_link = link_type'(slot);
               list_len++;
               push_expected(STATUS_APPENDED, item, 1'b1);
            end
         end
         MODE_DELETE: begin
            // Walk from the head and unlink only the first node that matches.
            cur    = head_link;
            walked = 0;
            found  = 1'b0;
            while (!found && walked < CAPACITY && link_live(cur)) begin
               if (list_value[cur[IDX_BITS-1:0]] == item) begin
                  found = 1'b1;
                  p = back_link[cur[IDX_BITS-1:0]];
                  q = fwd_link[cur[IDX_BITS-1:0]];
                  if (link_live(p)) fwd_link[p[IDX_BITS-1:0]] = q;
                  else head_link = q;
                  if (link_live(q)) back_link[q[IDX_BITS-1:0]] = p;
                  else tail_link = p;
                  node_busy[cur[IDX_BITS-1:0]] = 1'b0;
                  list_len--;
               end else begin
                  cur = fwd_link[cur[IDX_BITS-1:0]];
                  walked++;
               end
            end
            push_expected(found ? STATUS_DELETED : STATUS_NOT_FOUND, item, 1'b1);
         end
         default: begin
            // Both dumps: one element per live node, the final one marked.
            cur = (op == MODE_DUMP_FWD) ? head_link : tail_link;
            if (!link_live(cur)) begin
               push_expected(STATUS_EMPTY, '0, 1'b1);
            end else begin
               walked = 0;
               while (walked < CAPACITY && link_live(cur)) begin
                  nxt = (op == MODE_DUMP_FWD) ? fwd_link[cur[IDX_BITS-1:0]]
                                              : back_link[cur[IDX_BITS-1:0]];
                  push_expected(STATUS_ELEMENT, list_value[cur[IDX_BITS-1:0]],
                                !link_live(nxt) || (walked + 1) >= CAPACITY);
                  walked++;
                  cur = nxt;
               end
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Values lean toward a small set so that duplicates and matches are
   // common, with the extremes and fully random words mixed in.
   function automatic logic [ITEM_BITS-1:0] random_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
         1, 2, 3: return ITEM_BITS'($urandom_range(0, 7)) - 32'd4;
         default: return $urandom;
      endcase
   endfunction

   // Picks a value that is currently stored, so that a delete hits.
   function automatic logic [ITEM_BITS-1:0] stored_value();
      int live_nodes [$];
      for (int i = 0; i < CAPACITY; i++) begin
         if (node_busy[i]) live_nodes = {live_nodes, i};
      end
      if (live_nodes.size() == 0) begin
         return random_value();
      end
      return list_value[live_nodes[$urandom_range(0, live_nodes.size() - 1)]];
   endfunction

   // Gap after a request transfer: mostly none or short, a few long, and
   // now and then a stretch with no gaps at all.
   function automatic int sender_gap();
      int r;
      if (sender_quiet > 0) begin
         sender_quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
         sender_quiet = $urandom_range(5, 20);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   // Sends one request and waits for its transfer. When no gap follows, the
   // valid stays high so the next request is offered without a break.
   task automatic send_item(input mode_type op, input logic [ITEM_BITS-1:0] item);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= item;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_list_op(op, item);
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random back pressure and checking
   // ---------------------------------------------------------------------

   // Ready is mostly high, with short stalls, a few long ones and some
   // stretches without any stall.
   always @(posedge clock) begin
      int r;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (ready_quiet > 0) begin
         ready_quiet--;
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            ready_quiet = $urandom_range(20, 60);
            rsp_tready <= 1'b1;
         end else if (r < 28) begin
            stall_left = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else if (r < 31) begin
            stall_left = $urandom_range(7, 19);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic report_mismatch(input string field, input logic [ITEM_BITS-1:0] got,
                                  input logic [ITEM_BITS-1:0] want);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("%0t ns: %s is %h, expected %h", $time, field, got, want);
      end
   endtask

   // Each result transfer is compared field by field with the oldest
   // expectation. Signals are read right after the edge, so they hold the
   // values that the edge sampled.
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result transfer, data", rsp_tdata[31:0], '0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser !== want.status) begin
               report_mismatch("status", ITEM_BITS'(rsp_tuser), ITEM_BITS'(want.status));
            end
            if (rsp_tdata[31:0] !== want.value) begin
               report_mismatch("out_value", rsp_tdata[31:0], want.value);
            end
            if (rsp_tdata[37:32] !== want.count) begin
               report_mismatch("entry_count", ITEM_BITS'(rsp_tdata[37:32]),
                               ITEM_BITS'(want.count));
            end
            if (rsp_tdata[39:38] !== 2'b00) begin
               report_mismatch("tdata padding", ITEM_BITS'(rsp_tdata[39:38]), '0);
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch("last", ITEM_BITS'(rsp_tlast), ITEM_BITS'(want.last));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty dumps, a delete with nothing stored, extreme values, duplicates,
   // deletes at the head, the middle and the tail, and node reuse.
   task automatic test_directed();
      send_item(MODE_DUMP_FWD,  32'h0000_0000);
      send_item(MODE_DUMP_BACK, 32'hFFFF_FFFF);
      send_item(MODE_DELETE,    32'h0000_0005);
      send_item(MODE_APPEND,    32'h8000_0000);
      send_item(MODE_APPEND,    32'h7FFF_FFFF);
      send_item(MODE_APPEND,    32'h0000_0000);
      send_item(MODE_APPEND,    32'hFFFF_FFFF);
      send_item(MODE_APPEND,    32'h7FFF_FFFF);
      send_item(MODE_DUMP_FWD,  32'h1234_5678);
      send_item(MODE_DUMP_BACK, 32'h8765_4321);
      // Only the first of the two equal values goes; the second must remain.
      send_item(MODE_DELETE,    32'h7FFF_FFFF);
      send_item(MODE_DUMP_FWD,  32'h0000_0000);
      send_item(MODE_DELETE,    32'h8000_0000);
      send_item(MODE_DELETE,    32'h7FFF_FFFF);
      send_item(MODE_DELETE,    32'h0001_2345);
      send_item(MODE_DUMP_BACK, 32'h0000_0000);
      // The freed lowest node is reused and linked in at the tail.
      send_item(MODE_APPEND,    32'hAAAA_AAAA);
      send_item(MODE_DELETE,    32'hFFFF_FFFF);
      send_item(MODE_DELETE,    32'h0000_0000);
      send_item(MODE_DELETE,    32'hAAAA_AAAA);
      send_item(MODE_DUMP_FWD,  32'h0000_0000);
      send_item(MODE_APPEND,    32'h5555_5555);
      send_item(MODE_DELETE,    32'h5555_5555);
      send_item(MODE_DUMP_BACK, 32'h0000_0000);
   endtask

   // Fills the pool, appends while it is full, dumps the longest list both
   // ways, then thins and refills it before emptying it completely.
   task automatic test_fill_and_drain();
      while (list_len < CAPACITY) send_item(MODE_APPEND, random_value());
      send_item(MODE_APPEND, random_value());
      send_item(MODE_APPEND, $urandom);
      send_item(MODE_DUMP_FWD, $urandom);
      send_item(MODE_DUMP_BACK, $urandom);
      repeat (16) send_item(MODE_DELETE, stored_value());
      send_item(MODE_DELETE, $urandom);
      send_item(MODE_DUMP_FWD, $urandom);
      repeat (6) send_item(MODE_APPEND, random_value());
      send_item(MODE_DUMP_BACK, $urandom);
      while (list_len > 0) send_item(MODE_DELETE, stored_value());
      send_item(MODE_DUMP_FWD, $urandom);
   endtask

   // Mixed operations with random content; most deletes aim at a stored value.
   task automatic test_random_mix();
      int r;
      repeat (72) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            send_item(MODE_APPEND, random_value());
         end else if (r < 75) begin
            send_item(MODE_DELETE, ($urandom_range(0, 9) < 7) ? stored_value()
                                                                : random_value());
         end else if (r < 87) begin
            send_item(MODE_DUMP_FWD, $urandom);
         end else begin
            send_item(MODE_DUMP_BACK, $urandom);
         end
      end
   endtask

   initial begin
      reset_list();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fill_and_drain();
      test_random_mix();

      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      // Let any stray transfer show up before the verdict.
      repeat (CAPACITY + 10) @(posedge clock);

      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Safety limit, far beyond the slowest correct run.
   initial begin
      #10ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
